>>> rtl/core/sptd_pkg.sv
// sptd_pkg: shared constants for the seven-point timestamped derivative core
// holds field widths, tap geometry, weights and saturation limits
// no dependencies; used by the core, its port checker and the testbench
`default_nettype none

package sptd_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 48;
  localparam int FLAG_W   = 2;

  // tap geometry
  localparam int TAPS   = 7;
  localparam int CENTER = TAPS / 2;
  localparam int LANES  = 3;

  // tap index width and the two fixed slots used by the fill check
  localparam int                SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAPS - 1);
  localparam logic [SLOT_W-1:0] SLOT_PREV = SLOT_W'(TAPS - 2);

  // fixed point: q16.16 in, q16.32 out, divide by 32 folded in
  localparam int FRAC_SHIFT = 11;
  localparam int WEIGHT_W   = 5;
  localparam int MAG_W      = SAMPLE_W;
  localparam int PROD_W     = MAG_W + 4;
  localparam int QUOT_W     = PROD_W + FRAC_SHIFT;
  localparam int SUM_W      = RATE_W + 2;

  // divider iteration count
  localparam int                CNT_W    = 6;
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(QUOT_W - 1);

  // smoothing weights for the outer pairs, innermost first
  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [LANES] = '{5'd10, 5'd16, 5'd6};

  // saturation limits of the result
  localparam logic signed [SUM_W-1:0] RATE_MAX = SUM_W'((64'sd1 <<< (RATE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] RATE_MIN = -RATE_MAX - SUM_W'(1);

  // output flag positions in tuser
  localparam int FLAG_STORED = 0;
  localparam int FLAG_VALID  = 1;

endpackage : sptd_pkg

`default_nettype wire

>>> rtl/core/seven_point_timestamped_derivative_core.sv
// seven_point_timestamped_derivative_core: smoothed derivative over seven timestamped samples
// tap history in shift registers, three bit-serial restoring dividers, registered output word
// depends on sptd_pkg
//
// an accepted input word passes diff, scale, 47 divider steps and sum into the result
// word register; no new input word is taken until that result is loaded, and the radix-2
// dividers retire one quotient bit per cycle in all three lanes at once.
// a new input word is taken while the previous result still waits at the output.
// reset (rst_n low, synchronous) clears tap history, slot counter, fsm and output valid.
`default_nettype none

module seven_point_timestamped_derivative_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] sample_value, [63:32] time_stamp
  // master side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [47:0] climb_rate
  output logic [1:0]       out_tuser   // [0] accepted, [1] rate_valid
);

  // fsm codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // input fields
  logic [sptd_pkg::SAMPLE_W-1:0] in_sample;
  logic [sptd_pkg::TIME_W-1:0]   in_stamp;
  assign in_sample = in_tdata[sptd_pkg::SAMPLE_W-1:0];
  assign in_stamp  = in_tdata[sptd_pkg::SAMPLE_W +: sptd_pkg::TIME_W];

  // tap history, index TAPS-1 is the newest word
  logic [sptd_pkg::SAMPLE_W-1:0] samp_tap_r [sptd_pkg::TAPS];
  logic [sptd_pkg::TIME_W-1:0]   time_tap_r [sptd_pkg::TAPS];
  logic [sptd_pkg::SLOT_W-1:0]   slot_r;
  logic [sptd_pkg::TIME_W-1:0]   slot_prev_time_r;
  logic [sptd_pkg::TIME_W-1:0]   slot_last_time_r;

  logic in_fire;
  logic store_en;
  logic stored_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign store_en  = in_fire && (time_tap_r[sptd_pkg::TAPS-1] != in_stamp);

  // tap shift line and ring slot tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sptd_pkg::TAPS; i++) begin
        samp_tap_r[i] <= '0;
        time_tap_r[i] <= '0;
      end
      slot_r           <= '0;
      slot_prev_time_r <= '0;
      slot_last_time_r <= '0;
    end else if (store_en) begin
      for (int i = 0; i < sptd_pkg::TAPS - 1; i++) begin
        samp_tap_r[i] <= samp_tap_r[i+1];
        time_tap_r[i] <= time_tap_r[i+1];
      end
      samp_tap_r[sptd_pkg::TAPS-1] <= in_sample;
      time_tap_r[sptd_pkg::TAPS-1] <= in_stamp;
      if (slot_r == sptd_pkg::SLOT_PREV) begin
        slot_prev_time_r <= in_stamp;
      end
      if (slot_r == sptd_pkg::SLOT_LAST) begin
        slot_last_time_r <= in_stamp;
        slot_r           <= '0;
      end else begin
        slot_r <= slot_r + sptd_pkg::SLOT_W'(1);
      end
    end
  end

  // per-lane datapath
  logic [sptd_pkg::TIME_W-1:0]   dt_r    [sptd_pkg::LANES];
  logic signed [sptd_pkg::SAMPLE_W:0] diff_r [sptd_pkg::LANES];
  logic [sptd_pkg::QUOT_W-1:0]   num_r   [sptd_pkg::LANES];
  logic [sptd_pkg::TIME_W-1:0]   rem_r   [sptd_pkg::LANES];
  logic                          neg_r   [sptd_pkg::LANES];
  logic [sptd_pkg::LANES-1:0]    dt_zero;
  logic signed [sptd_pkg::SUM_W-1:0] term [sptd_pkg::LANES];

  for (genvar j = 0; j < sptd_pkg::LANES; j++) begin : g_lane
    localparam int HI = sptd_pkg::CENTER + j + 1;
    localparam int LO = sptd_pkg::CENTER - j - 1;

    logic signed [sptd_pkg::SAMPLE_W:0] diff_w;
    logic [sptd_pkg::MAG_W:0]           mag_w;
    logic [sptd_pkg::PROD_W:0]          prod_w;
    logic [sptd_pkg::TIME_W:0]          shifted;
    logic [sptd_pkg::TIME_W:0]          trial;
    logic                               ge;
    logic [sptd_pkg::RATE_W-1:0]        quot;
    logic [sptd_pkg::RATE_W-1:0]        sterm;

    // exact sample difference
    assign diff_w = $signed({samp_tap_r[HI][sptd_pkg::SAMPLE_W-1], samp_tap_r[HI]})
                  - $signed({samp_tap_r[LO][sptd_pkg::SAMPLE_W-1], samp_tap_r[LO]});

    // magnitude times the pair weight
    assign mag_w  = diff_r[j][sptd_pkg::SAMPLE_W] ? (sptd_pkg::MAG_W+1)'(-diff_r[j])
                                                  : (sptd_pkg::MAG_W+1)'(diff_r[j]);
    assign prod_w = (sptd_pkg::PROD_W+1)'(mag_w)
                  * (sptd_pkg::PROD_W+1)'(sptd_pkg::TAP_WEIGHT[j]);

    // one restoring divide step
    assign shifted = {rem_r[j], num_r[j][sptd_pkg::QUOT_W-1]};
    assign trial   = shifted - {1'b0, dt_r[j]};
    assign ge      = !trial[sptd_pkg::TIME_W];

    // signed term from the quotient
    assign quot  = sptd_pkg::RATE_W'(num_r[j]);
    assign sterm = neg_r[j] ? -quot : quot;
    assign term[j] = sptd_pkg::SUM_W'($signed(sterm));

    assign dt_zero[j] = (dt_r[j] == '0);

    always_ff @(posedge clk) begin
      case (state_r)
        ST_DIFF: begin
          dt_r[j]   <= time_tap_r[HI] - time_tap_r[LO];
          diff_r[j] <= diff_w;
        end
        ST_SCALE: begin
          num_r[j] <= {prod_w[sptd_pkg::PROD_W-1:0], sptd_pkg::FRAC_SHIFT'(0)};
          rem_r[j] <= '0;
          neg_r[j] <= diff_r[j][sptd_pkg::SAMPLE_W];
        end
        ST_DIV: begin
          num_r[j] <= {num_r[j][sptd_pkg::QUOT_W-2:0], ge};
          rem_r[j] <= ge ? trial[sptd_pkg::TIME_W-1:0] : shifted[sptd_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // stored flag, fill check and step counter
  logic                       filled_r;
  logic [sptd_pkg::CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stored_r <= store_en;
    end
    if (state_r == ST_DIFF) begin
      filled_r <= (slot_prev_time_r != slot_last_time_r);
    end
    if (state_r == ST_SCALE) begin
      cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      cnt_r <= cnt_r + sptd_pkg::CNT_W'(1);
    end
  end

  // sum and saturate
  logic signed [sptd_pkg::SUM_W-1:0] sum_w;
  logic signed [sptd_pkg::SUM_W-1:0] sat_w;
  logic                              rate_ok;

  assign sum_w   = term[0] + term[1] + term[2];
  assign rate_ok = filled_r && (dt_zero == '0);

  always_comb begin
    if (sum_w > sptd_pkg::RATE_MAX) begin
      sat_w = sptd_pkg::RATE_MAX;
    end else if (sum_w < sptd_pkg::RATE_MIN) begin
      sat_w = sptd_pkg::RATE_MIN;
    end else begin
      sat_w = sum_w;
    end
  end

  // output word register
  logic                          out_valid_r;
  logic [sptd_pkg::RATE_W-1:0]   out_rate_r;
  logic [sptd_pkg::FLAG_W-1:0]   out_flag_r;
  logic                          out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r <= rate_ok ? sat_w[sptd_pkg::RATE_W-1:0] : '0;
      out_flag_r[sptd_pkg::FLAG_STORED] <= stored_r;
      out_flag_r[sptd_pkg::FLAG_VALID]  <= rate_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rate_r;
  assign out_tuser  = out_flag_r;

  // control fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == sptd_pkg::DIV_LAST) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : seven_point_timestamped_derivative_core

`default_nettype wire

>>> rtl/core/sptd_checker.sv
// sptd_checker: port-level checks for the seven-point derivative core
// bound to seven_point_timestamped_derivative_core; depends on sptd_pkg
// holds the checker module and its bind statement
`default_nettype none

module sptd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a forced-zero rate reads as zero
  a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[sptd_pkg::FLAG_VALID] |-> out_tdata == '0)
    else $error("invalid rate with nonzero value");

  // the core is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken back to back");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule : sptd_checker

bind seven_point_timestamped_derivative_core sptd_checker u_sptd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench for seven_point_timestamped_derivative_core: directed and random sample words
// a scoreboard class predicts each result word; a task drives the input handshake, an always block the result side
// depends on sptd_pkg and the core rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                            CYCLE_LIMIT = 1_000_000;
  localparam int                            DRAIN_WAIT  = 60;
  localparam logic [sptd_pkg::SAMPLE_W-1:0] S_MAX       = 32'h7FFF_FFFF;
  localparam logic [sptd_pkg::SAMPLE_W-1:0] S_MIN       = 32'h8000_0000;

  // one expected result word
  typedef struct packed {
    logic [sptd_pkg::RATE_W-1:0] rate;
    logic                        stored;
    logic                        valid;
  } rate_word_t;

  // predicts the derivative from its own copy of the tap history
  class climb_rate_scoreboard;
    localparam longint RATE_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint RATE_LO    = -RATE_HI - 1;
    localparam int     CENTER_OFS = 3 * sptd_pkg::TAPS / 2;

    logic [sptd_pkg::SAMPLE_W-1:0] sample_ring [sptd_pkg::TAPS];
    logic [sptd_pkg::TIME_W-1:0]   time_ring [sptd_pkg::TAPS];
    int unsigned                   write_slot;
    rate_word_t                    expected_rates [$];
    int unsigned                   errors;

    function new();
      foreach (sample_ring[i]) begin
        sample_ring[i] = '0;
        time_ring[i]   = '0;
      end
      write_slot = 0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction

    // store the sample unless its stamp repeats, then predict the rate
    function void note_word(logic [sptd_pkg::SAMPLE_W-1:0] sample,
                            logic [sptd_pkg::TIME_W-1:0] stamp);
      int unsigned                 prev_slot;
      int unsigned                 hi;
      int unsigned                 lo;
      int                          k;
      longint                      weight;
      longint                      diff;
      longint                      sum;
      logic [sptd_pkg::TIME_W-1:0] dt;
      rate_word_t                  w;
      prev_slot = (write_slot == 0) ? sptd_pkg::TAPS - 1 : write_slot - 1;
      w.stored  = (time_ring[prev_slot] != stamp);
      if (w.stored) begin
        time_ring[write_slot]   = stamp;
        sample_ring[write_slot] = sample;
        write_slot              = (write_slot + 1) % sptd_pkg::TAPS;
      end
      // unfilled history looks at two fixed slots
      w.valid = (time_ring[sptd_pkg::SLOT_LAST] != time_ring[sptd_pkg::SLOT_PREV]);
      sum     = 0;
      for (k = 1; k <= 3 && w.valid; k++) begin
        hi     = (write_slot + CENTER_OFS + k) % sptd_pkg::TAPS;
        lo     = (write_slot + CENTER_OFS - k) % sptd_pkg::TAPS;
        dt     = time_ring[hi] - time_ring[lo];
        weight = (k == 1) ? 10 : (k == 2) ? 16 : 6;
        if (dt == 0) begin
          w.valid = 1'b0;
        end else begin
          diff = longint'($signed(sample_ring[hi])) - longint'($signed(sample_ring[lo]));
          // each lane truncates toward zero on its own
          sum += (weight * diff * 2048) / longint'({32'd0, dt});
        end
      end
      if (sum > RATE_HI) begin
        sum = RATE_HI;
      end else if (sum < RATE_LO) begin
        sum = RATE_LO;
      end
      w.rate = w.valid ? sum[sptd_pkg::RATE_W-1:0] : '0;
      expected_rates.push_back(w);
    endfunction

    function void report(string field, logic [sptd_pkg::RATE_W-1:0] exp_v,
                         logic [sptd_pkg::RATE_W-1:0] act_v);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, $signed(exp_v),
               $signed(act_v));
    endfunction

    // compare one result word against the oldest prediction
    function void check_word(logic [sptd_pkg::RATE_W-1:0] rate,
                             logic [sptd_pkg::FLAG_W-1:0] flags);
      rate_word_t w;
      if (expected_rates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, climb_rate %0d flags %b", $time,
                 $signed(rate), flags);
        return;
      end
      w = expected_rates[0];
      expected_rates.delete(0);
      if (rate !== w.rate) begin
        report("climb_rate", w.rate, rate);
      end
      if (flags[sptd_pkg::FLAG_STORED] !== w.stored) begin
        report("accepted", sptd_pkg::RATE_W'(w.stored),
               sptd_pkg::RATE_W'(flags[sptd_pkg::FLAG_STORED]));
      end
      if (flags[sptd_pkg::FLAG_VALID] !== w.valid) begin
        report("rate_valid", sptd_pkg::RATE_W'(w.valid),
               sptd_pkg::RATE_W'(flags[sptd_pkg::FLAG_VALID]));
      end
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [63:0]                   in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [sptd_pkg::RATE_W-1:0]   out_tdata;
  logic [sptd_pkg::FLAG_W-1:0]   out_tuser;

  climb_rate_scoreboard          sb;
  bit                            idle_on     = 1'b0;
  int                            stall_left  = 0;
  int                            cycle_count = 0;
  logic [sptd_pkg::TIME_W-1:0]   last_stamp  = '0;
  logic [sptd_pkg::SAMPLE_W-1:0] last_sample = '0;

  seven_point_timestamped_derivative_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_word(out_tdata, out_tuser);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one sample word, maybe after a gap, and hold it until taken
  task automatic send_word(input logic [sptd_pkg::SAMPLE_W-1:0] sample,
                           input logic [sptd_pkg::TIME_W-1:0] stamp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, sample};
    do @(posedge clk); while (!in_tready);
    sb.note_word(sample, stamp);
    last_stamp  = stamp;
    last_sample = sample;
  endtask

  // hold off the sender until every predicted word has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int                            blk;
    int                            n;
    int unsigned                   r;
    bit                            clean;
    logic [sptd_pkg::TIME_W-1:0]   step_max;
    logic [sptd_pkg::TIME_W-1:0]   pool_base;
    logic [sptd_pkg::TIME_W-1:0]   stamp;
    logic [sptd_pkg::SAMPLE_W-1:0] sample;

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero stamp right after reset repeats the cleared slot
    send_word(S_MAX, 32'd0);
    // each pair one tick apart, full positive swing: saturates high
    send_word(S_MIN, 300);
    send_word(S_MIN, 200);
    send_word(S_MIN, 100);
    send_word(32'd0, 50);
    send_word(S_MAX, 101);
    send_word(S_MAX, 201);
    send_word(S_MAX, 301);
    // same shape, negative swing: saturates low
    send_word(S_MAX, 1300);
    send_word(S_MAX, 1200);
    send_word(S_MAX, 1100);
    send_word(32'd0, 1050);
    send_word(S_MIN, 1101);
    send_word(S_MIN, 1201);
    send_word(S_MIN, 1301);
    // repeated stamp is dropped
    send_word(32'h0001_0000, 1301);
    // stamps wrap through zero, last word has a zero inner interval
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'h0000_0001, 32'd0);
    send_word(32'h8000_0001, 32'd1);
    send_word(32'hFFFF_0000, 32'd0);
    send_word(32'h0000_FFFF, 32'd2);
    send_word(32'h7FFF_0000, 32'd3);
    wait_for_results();

    // random blocks: mostly rising stamps, some noisy blocks, quiet tail
    for (blk = 0; blk < 20; blk++) begin
      idle_on   = (blk < 17) && ($urandom_range(0, 4) != 0);
      clean     = ($urandom_range(0, 9) < 6);
      pool_base = $urandom;
      case ($urandom_range(0, 2))
        0:       step_max = 4;
        1:       step_max = 5000;
        default: step_max = 32'hFFFF_FFFF;
      endcase
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < (clean ? 3 : 12)) begin
          stamp = last_stamp;
        end else if (!clean && r < 35) begin
          stamp = pool_base + $urandom_range(0, 5);
        end else if (!clean && r < 45) begin
          stamp = $urandom;
        end else begin
          stamp = last_stamp + $urandom_range(1, step_max);
        end
        r = $urandom_range(0, 9);
        if (r < 4) begin
          sample = $urandom;
        end else if (r < 9) begin
          sample = last_sample + $urandom_range(0, 4000) - 2000;
        end else begin
          case ($urandom_range(0, 3))
            0:       sample = S_MAX;
            1:       sample = S_MIN;
            2:       sample = '0;
            default: sample = '1;
          endcase
        end
        send_word(sample, stamp);
      end
      if (blk == 9) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
